// File: hdl/lz77_triple_decoder_defines.svh
// Assertion macros shared by the LZ77 triple decoder checker.
// Expects clk and rst in scope at the point of use.
`ifndef LZ77_TRIPLE_DECODER_DEFINES_SVH
`define LZ77_TRIPLE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lzd_pkg.sv
// Shared types and constants for the LZ77 triple decoder.
// No dependencies.
`default_nettype none

package lzd_pkg;

  localparam int OFFSET_W          = 13;
  localparam int LENGTH_W          = 6;
  localparam int BYTE_W            = 8;
  localparam int HISTORY_DEPTH_DEF = 4096;

  localparam logic [LENGTH_W-1:0] MAX_LENGTH = 6'd63;
  localparam logic [BYTE_W-1:0]   NO_SYMBOL  = 8'd32;

  typedef struct packed {
    logic [OFFSET_W-1:0] match_offset;
    logic [LENGTH_W-1:0] copy_len;
    logic                has_sym;
    logic [BYTE_W-1:0]   sym;
  } lzd_token_t;

endpackage

`default_nettype wire

// File: hdl/lzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/lzd_front.sv
// Front end: accepts tokens, classifies them and queues them for the back end.
// Depends on lzd_pkg.
`default_nettype none

module lzd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          token_valid,
  output logic                          token_stall,
  input  logic [lzd_pkg::OFFSET_W-1:0]  match_offset,
  input  logic [lzd_pkg::LENGTH_W-1:0]  match_length,
  input  logic [lzd_pkg::BYTE_W-1:0]    next_symbol,
  output logic                          tok_valid,
  output lzd_pkg::lzd_token_t           tok,
  input  logic                          tok_pop
);

  import lzd_pkg::*;

  lzd_token_t q [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;

  lzd_token_t entry;
  logic       accept;
  logic       push;
  logic       pop;

  always_comb begin
    entry.match_offset = match_offset;
    entry.has_sym      = (next_symbol != NO_SYMBOL);
    entry.sym          = next_symbol;
    if (match_offset == '0) begin
      entry.copy_len = '0;
    end else if (match_length > MAX_LENGTH) begin
      entry.copy_len = MAX_LENGTH;
    end else begin
      entry.copy_len = match_length;
    end
  end

  assign token_stall = (count == 2'd2);
  assign accept      = token_valid && !token_stall;
  // drop tokens that can give neither a result nor an error
  assign push        = accept && !((match_offset == '0) && !entry.has_sym);
  assign tok_valid   = (count != 2'd0);
  assign pop         = tok_pop && tok_valid;
  assign tok         = q[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_idx] <= entry;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lzd_back.sv
// Back end: runs queued tokens against the history ring and drives the result word.
// Depends on lzd_pkg and lzd_ram.
`default_nettype none

module lzd_back #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tok_valid,
  input  lzd_pkg::lzd_token_t         tok,
  output logic                        tok_pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [lzd_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last,
  output logic                        bad_reference
);

  import lzd_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int PW   = AW + 1;
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = (CW > OFFSET_W) ? CW : OFFSET_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_SYM  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  logic [2:0]          state, state_next;
  logic [AW-1:0]       wp, wp_next;
  logic [AW-1:0]       rd, rd_next;
  logic [CW-1:0]       avail, avail_next;
  logic [LENGTH_W-1:0] remain, remain_next;
  logic                has_sym, has_sym_next;
  logic [BYTE_W-1:0]   sym, sym_next;

  logic                out_load;
  logic [BYTE_W-1:0]   load_byte;
  logic                load_last;
  logic                load_bad;
  logic                out_free;

  logic                ram_we;
  logic                ram_re;
  logic [BYTE_W-1:0]   ram_rdata;

  logic                tok_err;
  logic [PW-1:0]       rd_sum;
  logic [AW-1:0]       rd_start;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  assign out_free = !result_valid || !result_stall;
  assign tok_err  = (tok.match_offset != '0) &&
                    (CMPW'(tok.match_offset) > CMPW'(avail));
  assign rd_sum   = PW'(wp) + (PW'(HISTORY_DEPTH) - PW'(tok.match_offset));
  assign rd_start = (rd_sum >= PW'(HISTORY_DEPTH)) ?
                    AW'(rd_sum - PW'(HISTORY_DEPTH)) : AW'(rd_sum);

  always_comb begin
    state_next   = state;
    wp_next      = wp;
    rd_next      = rd;
    avail_next   = avail;
    remain_next  = remain;
    has_sym_next = has_sym;
    sym_next     = sym;
    tok_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    load_byte    = ram_rdata;
    load_last    = 1'b0;
    load_bad     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (tok_valid) begin
          tok_pop      = 1'b1;
          remain_next  = tok.copy_len;
          has_sym_next = tok.has_sym;
          sym_next     = tok.sym;
          rd_next      = rd_start;
          priority if (tok_err) begin
            state_next = ST_ERR;
          end else if (tok.copy_len != '0) begin
            state_next = ST_READ;
          end else if (tok.has_sym) begin
            state_next = ST_SYM;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        rd_next    = ptr_inc(rd);
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          ram_we      = 1'b1;
          out_load    = 1'b1;
          load_byte   = ram_rdata;
          load_last   = (remain == LENGTH_W'(1)) && !has_sym;
          wp_next     = ptr_inc(wp);
          avail_next  = (avail == CW'(HISTORY_DEPTH)) ? avail : CW'(avail + 1'b1);
          remain_next = LENGTH_W'(remain - 1'b1);
          priority if (remain != LENGTH_W'(1)) begin
            state_next = ST_READ;
          end else if (has_sym) begin
            state_next = ST_SYM;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SYM: begin
        if (out_free) begin
          ram_we     = 1'b1;
          out_load   = 1'b1;
          load_byte  = sym;
          load_last  = 1'b1;
          wp_next    = ptr_inc(wp);
          avail_next = (avail == CW'(HISTORY_DEPTH)) ? avail : CW'(avail + 1'b1);
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_byte  = '0;
          load_last  = 1'b1;
          load_bad   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wp           <= '0;
      avail        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      avail <= avail_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd      <= rd_next;
    remain  <= remain_next;
    has_sym <= has_sym_next;
    sym     <= sym_next;
    if (out_load) begin
      out_byte      <= load_byte;
      last          <= load_last;
      bad_reference <= load_bad;
    end
  end

  lzd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp),
    .wr_data (load_byte),
    .rd_en   (ram_re),
    .rd_addr (rd),
    .rd_data (ram_rdata)
  );

endmodule

`default_nettype wire

// File: hdl/lz77_triple_decoder.sv
// LZ77 triple decoder top level: front end, token queue and back end with history ring.
// Depends on lzd_pkg, lzd_front, lzd_back and lzd_ram.
//
// Usage:
//   Token channel (token_valid/token_stall) takes one word of match_offset,
//   match_length and next_symbol. Result channel (result_valid/result_stall)
//   gives one decoded byte per word, with last on the final word of a token and
//   bad_reference on the single error word of an offset that reaches past the
//   bytes produced so far.
//   A two-entry queue sits between the front and the back end; token_stall rises
//   only when it is full.
//   Sequence: the back end takes a token in its idle state, then for each copied
//   byte does a registered ring read, then a write and emit; the trailing symbol
//   or the error word follows. It takes no new token until the last is finished.
//   Tokens with a zero offset and symbol 32 give no word.
//   The first word of a symbol-only or error token is registered from the state
//   after the idle state; a copy adds the registered ring read before it.
//   Reset clears the queue, the ring pointer and the byte count; the ring itself
//   is not cleared and needs no clearing pass.
//   While result_stall is high with result_valid set, the result word holds and the back end waits.
`default_nettype none

module lz77_triple_decoder #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          token_valid,
  output logic                          token_stall,
  input  logic [lzd_pkg::OFFSET_W-1:0]  match_offset,
  input  logic [lzd_pkg::LENGTH_W-1:0]  match_length,
  input  logic [lzd_pkg::BYTE_W-1:0]    next_symbol,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [lzd_pkg::BYTE_W-1:0]    out_byte,
  output logic                          last,
  output logic                          bad_reference
);

  import lzd_pkg::*;

  logic       tok_valid;
  lzd_token_t tok;
  logic       tok_pop;

  lzd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .match_offset (match_offset),
    .match_length (match_length),
    .next_symbol  (next_symbol),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_pop      (tok_pop)
  );

  lzd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .tok_valid     (tok_valid),
    .tok           (tok),
    .tok_pop       (tok_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .last          (last),
    .bad_reference (bad_reference)
  );

endmodule

`default_nettype wire

// File: hdl/lzd_checker.sv
// Port-level checker for the LZ77 triple decoder, bound to the top level.
// Depends on lzd_pkg and lz77_triple_decoder_defines.svh.
`default_nettype none
`include "lz77_triple_decoder_defines.svh"

module lzd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          token_valid,
  input  logic                          token_stall,
  input  logic [lzd_pkg::OFFSET_W-1:0]  match_offset,
  input  logic [lzd_pkg::LENGTH_W-1:0]  match_length,
  input  logic [lzd_pkg::BYTE_W-1:0]    next_symbol,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [lzd_pkg::BYTE_W-1:0]    out_byte,
  input  logic                          last,
  input  logic                          bad_reference
);

  `LZD_ASSERT_NOW(a_err_word, result_valid && bad_reference, last && (out_byte == '0), "error word must be last with zero byte")

  `LZD_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(out_byte) && $stable(last) && $stable(bad_reference), "stalled result word changed")

  `LZD_ASSERT_NOW(a_after_reset, $past(rst), !token_stall && !result_valid, "queue or result not empty after reset")

  `LZD_ASSERT_NEXT(a_err_mid_token, result_valid && !result_stall && !last, !(result_valid && bad_reference), "error word inside a token")

endmodule

bind lz77_triple_decoder lzd_checker u_chk (.*);

`default_nettype wire

// File: test/lzd_stream_checker.sv
// Scoreboard for the LZ77 triple decoder: tracks the decoded history and expected words.
// Watches the token and result channels; depends on lzd_pkg.
module lzd_stream_checker #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         token_valid,
  input  logic                         token_stall,
  input  logic [lzd_pkg::OFFSET_W-1:0] match_offset,
  input  logic [lzd_pkg::LENGTH_W-1:0] match_length,
  input  logic [lzd_pkg::BYTE_W-1:0]   next_symbol,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic [lzd_pkg::BYTE_W-1:0]   out_byte,
  input  logic                         last,
  input  logic                         bad_reference,
  output int                           pending_words,
  output int                           mismatches
);

  import lzd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              bad;
  } dec_word_t;

  dec_word_t expected_words[$];
  logic [BYTE_W-1:0] history [HISTORY_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW:0]       fill;

  initial begin
    mismatches    = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_word(input logic [BYTE_W-1:0] b, input logic l, input logic e);
    dec_word_t w;
    w.data = b;
    w.last = l;
    w.bad  = e;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic store_byte(input logic [BYTE_W-1:0] b);
    history[wr_ptr] = b;
    wr_ptr = (int'(wr_ptr) == HISTORY_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
    if (fill < HISTORY_DEPTH) fill = fill + 1'b1;
  endtask

  task automatic decode_token(input logic [OFFSET_W-1:0] ofs, input logic [LENGTH_W-1:0] len,
                              input logic [BYTE_W-1:0] sym);
    int rd;
    int n_copy;
    int total;
    logic has_sym;
    logic [BYTE_W-1:0] b;
    has_sym = (sym != NO_SYMBOL);
    n_copy = 0;
    rd = 0;
    if (ofs != 0) begin
      // offset past the bytes produced: single error word, drop the symbol
      if (ofs > fill) begin
        push_word('0, 1'b1, 1'b1);
        return;
      end
      n_copy = (len > MAX_LENGTH) ? int'(MAX_LENGTH) : int'(len);
      rd = (int'(wr_ptr) + HISTORY_DEPTH - int'(ofs)) % HISTORY_DEPTH;
    end
    total = n_copy + (has_sym ? 1 : 0);
    for (int i = 0; i < n_copy; i++) begin
      b = history[rd[AW-1:0]];
      rd = (rd + 1) % HISTORY_DEPTH;
      store_byte(b);
      push_word(b, (i + 1 == total), 1'b0);
    end
    if (has_sym) begin
      store_byte(sym);
      push_word(sym, 1'b1, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    dec_word_t want;
    if (rst) begin
      expected_words.delete();
      wr_ptr = '0;
      fill   = '0;
      pending_words <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word, out_byte", int'(out_byte), 0);
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", int'(out_byte), int'(want.data));
          if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
          if (bad_reference !== want.bad)
            report_mismatch("bad_reference", int'(bad_reference), int'(want.bad));
        end
      end
      if (token_valid && !token_stall) decode_token(match_offset, match_length, next_symbol);
      pending_words <= expected_words.size();
    end
  end

endmodule

// File: test/lz77_triple_decoder_tb.sv
// Top-level testbench for lz77_triple_decoder: clock, reset, token stimulus and verdict.
// Depends on lzd_pkg, the decoder RTL and lzd_stream_checker.
module lz77_triple_decoder_tb;
  import lzd_pkg::*;

  localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEF;
  localparam int QUIET_LIMIT   = 5000;

  logic                clk;
  logic                rst;
  logic                token_valid;
  logic                token_stall;
  logic [OFFSET_W-1:0] match_offset;
  logic [LENGTH_W-1:0] match_length;
  logic [BYTE_W-1:0]   next_symbol;
  logic                result_valid;
  logic                result_stall;
  logic [BYTE_W-1:0]   out_byte;
  logic                last;
  logic                bad_reference;

  int pending_words;
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int fill_est;
  int quiet_cycles;

  lz77_triple_decoder #(.HISTORY_DEPTH(HISTORY_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .match_offset  (match_offset),
    .match_length  (match_length),
    .next_symbol   (next_symbol),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .last          (last),
    .bad_reference (bad_reference)
  );

  lzd_stream_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_stream_chk (
    .clk           (clk),
    .rst           (rst),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .match_offset  (match_offset),
    .match_length  (match_length),
    .next_symbol   (next_symbol),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .last          (last),
    .bad_reference (bad_reference),
    .pending_words (pending_words),
    .mismatches    (mismatches)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (token_valid && !token_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_token(input logic [OFFSET_W-1:0] ofs, input logic [LENGTH_W-1:0] len,
                            input logic [BYTE_W-1:0] sym, output int words);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      token_valid <= 1'b0;
      @(posedge clk);
    end
    token_valid  <= 1'b1;
    match_offset <= ofs;
    match_length <= len;
    next_symbol  <= sym;
    @(negedge clk);
    while (token_stall) @(negedge clk);
    @(posedge clk);
    if (ofs != 0 && int'(ofs) > fill_est) begin
      words = 1;
    end else begin
      words = ((ofs != 0) ? int'(len) : 0) + ((sym != NO_SYMBOL) ? 1 : 0);
      fill_est = (fill_est + words > HISTORY_DEPTH) ? HISTORY_DEPTH : fill_est + words;
    end
  endtask

  // hold the sender until every expected word has come out
  task automatic drain_then_set(input int send_pct, input int recv_pct);
    token_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(posedge clk);
  endtask

  task automatic send_random(input int wanted);
    int made;
    int pick;
    int reach;
    int words;
    logic [OFFSET_W-1:0] ofs;
    logic [LENGTH_W-1:0] len;
    logic [BYTE_W-1:0]   sym;
    made = 0;
    while (made < wanted) begin
      pick  = $urandom_range(0, 99);
      reach = (fill_est < HISTORY_DEPTH) ? fill_est : HISTORY_DEPTH;
      if (pick < 10) begin
        ofs = '0;
      end else if (pick < 20) begin
        ofs = (fill_est < HISTORY_DEPTH) ?
              OFFSET_W'($urandom_range(HISTORY_DEPTH, fill_est + 1)) :
              OFFSET_W'(HISTORY_DEPTH);
      end else if (reach == 0) begin
        ofs = '0;
      end else if (pick < 25) begin
        ofs = OFFSET_W'(reach);
      end else if (pick < 50) begin
        ofs = OFFSET_W'($urandom_range(1, (reach < 8) ? reach : 8));
      end else begin
        ofs = OFFSET_W'($urandom_range(1, reach));
      end
      len = ($urandom_range(0, 99) < 55) ? LENGTH_W'($urandom_range(40, 63)) :
                                           LENGTH_W'($urandom_range(0, 63));
      sym = ($urandom_range(0, 99) < 15) ? NO_SYMBOL : BYTE_W'($urandom_range(0, 255));
      send_token(ofs, len, sym, words);
      if (words > 0) made++;
    end
  endtask

  initial begin
    int words;
    rst            = 1'b1;
    token_valid    = 1'b0;
    match_offset   = '0;
    match_length   = '0;
    next_symbol    = '0;
    result_stall   = 1'b0;
    quiet_cycles   = 0;
    fill_est       = 0;
    send_idle_pct  = 8;
    recv_stall_pct = 63;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_token(13'd1,    6'd5,  8'h41, words);
    send_token(13'd4096, 6'd63, 8'h00, words);
    send_token(13'd0,    6'd63, 8'h00, words);
    send_token(13'd0,    6'd0,  NO_SYMBOL, words);
    send_token(13'd0,    6'd0,  8'hFF, words);
    send_token(13'd0,    6'd17, 8'hAA, words);
    send_token(13'd1,    6'd63, NO_SYMBOL, words);
    send_token(13'd3,    6'd0,  NO_SYMBOL, words);
    send_token(13'd66,   6'd0,  8'h55, words);
    send_token(13'd68,   6'd1,  8'h01, words);
    send_token(13'd67,   6'd63, 8'h7F, words);
    send_token(13'd2,    6'd7,  NO_SYMBOL, words);
    send_token(13'd3,    6'd1,  8'h80, words);
    send_token(13'd0,    6'd42, NO_SYMBOL, words);
    send_token(13'd140,  6'd40, 8'h00, words);
    send_token(13'd182,  6'd63, 8'hFF, words);
    send_token(13'd181,  6'd63, NO_SYMBOL, words);
    send_token(13'd5,    6'd63, 8'hC3, words);
    drain_then_set(8, 63);

    send_random(34);
    drain_then_set(63, 8);
    send_random(34);
    drain_then_set(0, 0);
    send_random(34);
    drain_then_set(0, 0);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
